[rtl/core/smmr_pkg.sv]
// smmr_pkg: shared types and constants for the segmented max/min reducer
// no dependencies
`default_nettype none
package smmr_pkg;
   localparam int ACC_DEPTH = 256;
   localparam int COL_W = 8;
   localparam int VAL_W = 32;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REDUCE_MODE  = 1'b0,
      CSR_VALUE_FORMAT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             fold;   // compare against stored value
      logic             last;   // emit result
      logic             empty;  // emit zero
      logic             mode;   // 1 = min
      logic             half;   // fp16
      logic [COL_W-1:0] col;
      logic [VAL_W-1:0] val;
   } op_type;

   // true when a orders strictly above b, signed-magnitude with -0 == +0
   function automatic logic key_gt(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                                   input logic half);
      logic sa, sb;
      logic [30:0] ma, mb;
      begin
         sa = half ? a[15] : a[31];
         sb = half ? b[15] : b[31];
         ma = half ? {16'd0, a[14:0]} : a[30:0];
         mb = half ? {16'd0, b[14:0]} : b[30:0];
         if (ma == 31'd0) sa = 1'b0;
         if (mb == 31'd0) sb = 1'b0;
         case ({sa, sb})
            2'b00:   key_gt = ma > mb;
            2'b11:   key_gt = ma < mb;
            2'b01:   key_gt = 1'b1;
            default: key_gt = 1'b0;
         endcase
      end
   endfunction
endpackage
`default_nettype wire

[rtl/core/smmr_acc_mem.sv]
// smmr_acc_mem: column accumulator memory, one write and one registered read port
// depends on smmr_pkg
`default_nettype none
module smmr_acc_mem (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [smmr_pkg::COL_W-1:0] wr_addr,
   input  wire [smmr_pkg::VAL_W-1:0] wr_data,
   input  wire                       rd_en,
   input  wire [smmr_pkg::COL_W-1:0] rd_addr,
   output logic [smmr_pkg::VAL_W-1:0] rd_data
);
   import smmr_pkg::*;
   logic [VAL_W-1:0] mem [ACC_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end
   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/core/segmented_max_min_reduce_top.sv]
// segmented_max_min_reduce_top: per-column max/min reduction over a request stream
// depends on smmr_pkg, smmr_acc_mem
//
// channel   dir  fields
// req_*     in   tdata {empty_row, last_neighbor, first_neighbor, column, feature_value}
// rsp_*     out  tdata {result_column, result_value}
// csr_*     in   index 0 reduce_mode, 1 value_format
//
// one request per cycle while req_tready is high; memory read, then compare/writeback
// the accumulator memory has a registered read; same-column back-to-back is forwarded
// reset clears control and csr only; accumulators are undefined until a first neighbor
// rsp output register plus a skid slot keep req_tready high while one result waits
`default_nettype none
module segmented_max_min_reduce_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // [31:0] feature_value, [39:32] column,
                                    // [40] first_neighbor, [41] last_neighbor, [42] empty_row
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] result_value, [39:32] result_column
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire         csr_wdata
);
   import smmr_pkg::*;

   logic mode_ff, half_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         half_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_REDUCE_MODE:  mode_ff <= csr_wdata;
            CSR_VALUE_FORMAT: half_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // stage 1: decode request, launch memory read
   op_type s1_in;
   always_comb begin
      s1_in.fold  = !req_tdata[40];
      s1_in.last  = req_tdata[41];
      s1_in.empty = req_tdata[42];
      s1_in.mode  = mode_ff;
      s1_in.half  = half_ff;
      s1_in.col   = req_tdata[39:32];
      s1_in.val   = half_ff ? {16'd0, req_tdata[15:0]} : req_tdata[31:0];
   end

   op_type s1_ff;
   logic   s1_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= req_acc;
      if (req_acc) s1_ff <= s1_in;
   end

   // stage 2: compare and write back
   logic             wr_en;
   logic [VAL_W-1:0] wr_data, mem_rd, acc_old;
   logic [VAL_W-1:0] fwd_data_ff;
   logic             fwd_vld_ff;

   smmr_acc_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (wr_data),
      .rd_en   (req_acc),
      .rd_addr (s1_in.col),
      .rd_data (mem_rd)
   );

   // forward the write from the previous cycle (same col read raced it)
   always_ff @(posedge clock) begin
      if (reset) fwd_vld_ff <= 1'b0;
      else       fwd_vld_ff <= req_acc && wr_en && (s1_ff.col == s1_in.col);
      fwd_data_ff <= wr_data;
   end

   logic gt, take;
   always_comb begin
      acc_old = fwd_vld_ff ? fwd_data_ff : mem_rd;
      if (s1_ff.half) acc_old = {16'd0, acc_old[15:0]};
      gt   = s1_ff.mode ? key_gt(acc_old, s1_ff.val, s1_ff.half)
                        : key_gt(s1_ff.val, acc_old, s1_ff.half);
      take = !s1_ff.fold || gt;
      wr_data = take ? s1_ff.val : acc_old;
      wr_en   = s1_vld_ff && !s1_ff.empty;
   end

   logic             res_vld;
   logic [39:0]      res_data;
   assign res_vld  = s1_vld_ff && (s1_ff.empty || s1_ff.last);
   assign res_data = {s1_ff.col, s1_ff.empty ? {VAL_W{1'b0}} : wr_data};

   // output register with skid slot; ready drops while a result is filling the
   // skid behind a blocked output, and while the skid holds a result
   logic        skid_vld_ff;
   logic [39:0] skid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!rsp_tvalid || rsp_tready) begin
            if (skid_vld_ff) begin
               rsp_tvalid  <= 1'b1;
               rsp_tdata   <= skid_ff;
               skid_vld_ff <= res_vld;
               skid_ff     <= res_data;
            end else begin
               rsp_tvalid <= res_vld;
               rsp_tdata  <= res_data;
            end
         end else if (res_vld) begin
            skid_vld_ff <= 1'b1;
            skid_ff     <= res_data;
         end
      end
   end

   // stall when skid is full, or filling while the output is blocked
   assign req_tready = !skid_vld_ff && !(res_vld && rsp_tvalid && !rsp_tready);

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && rsp_tvalid && !rsp_tready) |-> !res_vld)
      else $error("result dropped: skid full");
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_tvalid)
      else $error("skid holds data while output empty");
   a_stage_follows: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_vld_ff)
      else $error("accepted request lost in stage 1");
`endif
endmodule
`default_nettype wire
